[hw/rtl/lfmr_pkg.sv]
// lfmr_pkg: shared types and constants for the length framed message ring.
// No dependencies.
`timescale 1ns / 1ps

package lfmr_pkg;

  localparam int RING_BYTES_DEF        = 256;
  localparam int MAX_MESSAGE_BYTES_DEF = 64;
  localparam int MIN_MESSAGE_BYTES     = 2;
  localparam int BYTE_W                = 8;
  localparam int COUNT_W               = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam int QUEUE_DEPTH           = 2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PUSH_END,
    OP_POP
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [BYTE_W-1:0] data;
  } item_t;

endpackage

[hw/rtl/lfmr_if.sv]
// lfmr_req_if / lfmr_rsp_if: valid-ready channels for requests and results.
// No dependencies.
`timescale 1ns / 1ps

interface lfmr_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] push_byte;
  logic       push_end;

  modport source (output valid, cmd, push_byte, push_end, input ready);
  modport sink   (input valid, cmd, push_byte, push_end, output ready);
endinterface

interface lfmr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       queue_empty;
  logic       byte_dropped;

  modport source (output valid, out_byte, out_last, queue_empty, byte_dropped, input ready);
  modport sink   (input valid, out_byte, out_last, queue_empty, byte_dropped, output ready);
endinterface

[hw/rtl/lfmr_front.sv]
// lfmr_front: accepts requests, decodes them into items, holds them in a short queue.
// Depends on lfmr_pkg and lfmr_req_if.
`timescale 1ns / 1ps

module lfmr_front import lfmr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lfmr_req_if.sink          request,
  output logic              item_valid,
  input  logic              item_take,
  output item_t             item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  item_t              decoded;
  logic               put;
  logic               get;

  always_comb begin
    decoded.data = request.push_byte;
    if (request.cmd) begin
      decoded.kind = OP_POP;
    end else if (request.push_end) begin
      decoded.kind = OP_PUSH_END;
    end else begin
      decoded.kind = OP_PUSH;
    end
  end

  assign request.ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign put           = request.valid && request.ready;
  assign item_valid    = (fill != '0);
  assign get           = item_take && item_valid;
  assign item          = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (put) begin
      entry[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (put) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (get) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({put, get})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/lfmr_back.sv]
// lfmr_back: byte ring memory, counters and pop sequencer with result register.
// Depends on lfmr_pkg and lfmr_rsp_if.
`timescale 1ns / 1ps

module lfmr_back import lfmr_pkg::*; #(
  parameter int RING_BYTES        = RING_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_take,
  input  item_t             item,
  lfmr_rsp_if.source        result
);

  localparam int IDX_W = $clog2(RING_BYTES);
  localparam int CNT_W = $clog2(RING_BYTES + 1);
  localparam int K_W   = $clog2(MAX_MESSAGE_BYTES + 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  logic [BYTE_W-1:0]  ring [RING_BYTES];
  logic [BYTE_W-1:0]  rd_data;

  state_t             state;
  logic [IDX_W-1:0]   write_index;
  logic [IDX_W-1:0]   read_index;
  logic [COUNT_W-1:0] message_count;
  logic [CNT_W-1:0]   bytes_held;
  logic [K_W-1:0]     taken;
  logic [K_W-1:0]     want;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic               queue_empty;
  logic               byte_dropped;

  logic               slot_free;
  logic               full;
  logic               none;
  logic               is_pop;
  logic               needs_slot;
  logic               mem_we;
  logic               mem_re;
  logic               issue_first;
  logic               issue_next;
  logic               load;
  logic               emit;
  logic               last;
  logic [K_W-1:0]     want_c;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_BYTES - 1)) ? '0 : i + 1'b1;
  endfunction

  assign slot_free  = !out_valid || result.ready;
  assign full       = (bytes_held == CNT_W'(RING_BYTES));
  assign none       = (message_count == '0) || (bytes_held == '0);
  assign is_pop     = (item.kind == OP_POP);
  assign needs_slot = is_pop ? none : full;
  assign item_take  = (state == ST_IDLE) && item_valid && (!needs_slot || slot_free);

  assign mem_we      = item_take && !is_pop && !full;
  assign issue_first = item_take && is_pop && !none;
  assign load        = (state == ST_READ) && slot_free;
  assign emit        = ((state == ST_IDLE) && item_take && needs_slot) || load;

  always_comb begin
    if (rd_data < BYTE_W'(MIN_MESSAGE_BYTES)) begin
      want_c = K_W'(MIN_MESSAGE_BYTES);
    end else if (rd_data > BYTE_W'(MAX_MESSAGE_BYTES)) begin
      want_c = K_W'(MAX_MESSAGE_BYTES);
    end else begin
      want_c = K_W'(rd_data);
    end
    if (taken == K_W'(1)) begin
      last = (bytes_held == '0);
    end else if (taken == K_W'(2)) begin
      last = (want_c <= K_W'(2)) || (bytes_held == '0);
    end else begin
      last = (taken == want) || (bytes_held == '0);
    end
  end

  assign issue_next = load && !last;
  assign mem_re     = issue_first || issue_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[write_index] <= item.data;
    end
    if (mem_re) begin
      rd_data <= ring[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_index   <= '0;
      read_index    <= '0;
      message_count <= '0;
      bytes_held    <= '0;
      taken         <= '0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !result.ready);

      if (mem_we) begin
        write_index <= advance(write_index);
        bytes_held  <= bytes_held + 1'b1;
        if ((item.kind == OP_PUSH_END) && (message_count != COUNT_MAX)) begin
          message_count <= message_count + 1'b1;
        end
      end

      if (mem_re) begin
        read_index <= advance(read_index);
        bytes_held <= bytes_held - 1'b1;
        taken      <= issue_first ? K_W'(1) : taken + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (item_take && needs_slot) begin
            out_byte     <= '0;
            out_last     <= 1'b1;
            queue_empty  <= is_pop;
            byte_dropped <= !is_pop;
            if (is_pop && (bytes_held == '0)) begin
              message_count <= '0;
            end
          end
          if (issue_first) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (load) begin
            out_byte     <= rd_data;
            out_last     <= last;
            queue_empty  <= 1'b0;
            byte_dropped <= 1'b0;
            if (taken == K_W'(2)) begin
              want <= want_c;
            end
            if (last) begin
              message_count <= message_count - 1'b1;
              state         <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.out_byte     = out_byte;
  assign result.out_last     = out_last;
  assign result.queue_empty  = queue_empty;
  assign result.byte_dropped = byte_dropped;

endmodule

[hw/rtl/length_framed_message_ring.sv]
// length_framed_message_ring: top level, front decode queue feeding the ring engine.
// Depends on lfmr_pkg, lfmr_if, lfmr_front, lfmr_back.
//
//   channel   dir   fields                                        accepted when
//   request   in    cmd, push_byte, push_end                      valid && ready
//   result    out   out_byte, out_last, queue_empty, byte_dropped valid && ready
//
// Requests enter a two-entry queue at one per cycle while it has room.
// A push writes one ring byte; a full-ring push or an empty pop waits for a
// free result slot and returns a single result. A pop first reads the ring,
// then one byte per cycle leaves the registered memory port, barring result stalls.
// Reset (rst, synchronous) empties the ring; no clearing pass. Result stalls
// hold the engine; requests keep queuing until the queue fills.
`timescale 1ns / 1ps

module length_framed_message_ring import lfmr_pkg::*; #(
  parameter int RING_BYTES        = RING_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lfmr_req_if.sink   request,
  lfmr_rsp_if.source result
);

  logic  item_valid;
  logic  item_take;
  item_t item;

  lfmr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  lfmr_back #(
    .RING_BYTES        (RING_BYTES),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .result     (result)
  );

endmodule
